// ===== hdl/seven_segment_scan_sniffer_core_assert.svh =====
// Assertion macros for the seven-segment scan sniffer.
// Included by the top level; needs only a clock and a synchronous reset.
`ifndef SEVEN_SEGMENT_SCAN_SNIFFER_CORE_ASSERT_SVH
`define SEVEN_SEGMENT_SCAN_SNIFFER_CORE_ASSERT_SVH

// Antecedent in a cycle implies consequent in the next.
`define SSS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the same cycle.
`define SSS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== hdl/sss_pkg.sv =====
// Shared constants and the queue entry type of the scan sniffer.
// No dependencies; compiled first.
`default_nettype none

package sss_pkg;

  localparam int SelW      = 3;  // digit-select lines carried per snapshot
  localparam int SegW      = 7;  // segments A..G
  localparam int MaxDigits = 3;  // digits with a field in the report
  localparam int DigitW    = 2;  // digit index in a queue entry
  localparam int CountW    = 3;  // match counter and threshold

  localparam logic [CountW-1:0] ThrReset = 3'd3;

  localparam logic OpSample = 1'b0;
  localparam logic OpReport = 1'b1;

  // One classified transaction handed from front to back.
  typedef struct packed {
    logic              opcode;
    logic [DigitW-1:0] digit;
    logic [SegW-1:0]   segments;
    logic              point;
  } sss_op_t;

endpackage

`default_nettype wire

// ===== hdl/sss_ifs.sv =====
// Channel interfaces: command input, report output, threshold write.
// Depends on sss_pkg for field widths.
`default_nettype none

interface sss_cmd_if;
  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic [sss_pkg::SelW-1:0]  select_lines_first;
  logic [sss_pkg::SelW-1:0]  select_lines_second;
  logic [sss_pkg::SelW-1:0]  select_lines_third;
  logic [sss_pkg::SegW-1:0]  segments_first;
  logic [sss_pkg::SegW-1:0]  segments_second;
  logic [sss_pkg::SegW-1:0]  segments_third;
  logic                      point_first;
  logic                      point_second;
  logic                      point_third;

  modport source (
    output valid, opcode, select_lines_first, select_lines_second, select_lines_third,
           segments_first, segments_second, segments_third,
           point_first, point_second, point_third,
    input  ready
  );
  modport sink (
    input  valid, opcode, select_lines_first, select_lines_second, select_lines_third,
           segments_first, segments_second, segments_third,
           point_first, point_second, point_third,
    output ready
  );
endinterface

interface sss_report_if;
  logic                          valid;
  logic                          ready;
  logic [sss_pkg::SegW-1:0]      digit0_segments;
  logic [sss_pkg::SegW-1:0]      digit1_segments;
  logic [sss_pkg::SegW-1:0]      digit2_segments;
  logic                          digit0_point;
  logic                          digit1_point;
  logic                          digit2_point;
  logic [sss_pkg::MaxDigits-1:0] fresh_flags;

  modport source (
    output valid, digit0_segments, digit1_segments, digit2_segments,
           digit0_point, digit1_point, digit2_point, fresh_flags,
    input  ready
  );
  modport sink (
    input  valid, digit0_segments, digit1_segments, digit2_segments,
           digit0_point, digit1_point, digit2_point, fresh_flags,
    output ready
  );
endinterface

interface sss_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [sss_pkg::CountW-1:0] confirm_threshold;

  modport source (output valid, confirm_threshold, input ready);
  modport sink (input valid, confirm_threshold, output ready);
endinterface

`default_nettype wire

// ===== hdl/sss_front.sv =====
// Front end: takes command transactions, checks sample consistency,
// pushes reports and good samples to the queue. Depends on sss_pkg, sss_ifs.
`default_nettype none

module sss_front #(
  parameter int NUM_DIGITS = 3
) (
  sss_cmd_if.sink          cmd,
  input  wire logic        q_ready,
  output sss_pkg::sss_op_t q_data,
  output logic             q_push
);
  import sss_pkg::*;

  localparam int NumLive = (NUM_DIGITS < MaxDigits) ? NUM_DIGITS : MaxDigits;

  typedef struct packed {
    logic              one;
    logic [DigitW-1:0] idx;
  } sel_t;

  // Exactly one low line among the live digits; lines of absent digits count high.
  function automatic sel_t single_low(input logic [SelW-1:0] lines);
    sel_t        r;
    logic [1:0]  cnt;
    r   = '0;
    cnt = '0;
    for (int i = 0; i < NumLive; i++) begin
      if (!lines[i]) begin
        if (cnt != 2'd2) cnt = cnt + 2'd1;
        r.idx = DigitW'(i);
      end
    end
    r.one = (cnt == 2'd1);
    return r;
  endfunction

  sel_t s1, s2, s3;
  logic sample_ok;

  always_comb begin
    s1 = single_low(cmd.select_lines_first);
    s2 = single_low(cmd.select_lines_second);
    s3 = single_low(cmd.select_lines_third);
    sample_ok = s1.one && s2.one && s3.one && (s1.idx == s2.idx) && (s1.idx == s3.idx)
             && (cmd.segments_first == cmd.segments_second)
             && (cmd.segments_second == cmd.segments_third)
             && (cmd.point_first == cmd.point_second)
             && (cmd.point_second == cmd.point_third);
  end

  assign cmd.ready = q_ready;

  // Rejected samples are accepted and dropped here.
  assign q_push = cmd.valid && q_ready && ((cmd.opcode == OpReport) || sample_ok);

  always_comb begin
    q_data.opcode   = cmd.opcode;
    q_data.digit    = s1.idx;
    q_data.segments = cmd.segments_first;
    q_data.point    = cmd.point_first;
  end

endmodule

`default_nettype wire

// ===== hdl/sss_queue.sv =====
// Two-entry queue of classified transactions between front and back.
// Depends on sss_pkg.
`default_nettype none

module sss_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire sss_pkg::sss_op_t push_data,
  output logic                  not_full,
  input  wire logic             pop,
  output logic                  not_empty,
  output sss_pkg::sss_op_t      head
);
  import sss_pkg::*;

  sss_op_t    slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign not_full  = (count != 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

endmodule

`default_nettype wire

// ===== hdl/sss_back.sv =====
// Back end: per-digit debounce state, confirmed values, fresh bits and
// the registered report output. Depends on sss_pkg, sss_ifs.
`default_nettype none

module sss_back #(
  parameter int NUM_DIGITS = 3
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [sss_pkg::CountW-1:0] threshold,
  input  wire logic                       q_valid,
  input  wire sss_pkg::sss_op_t           q_data,
  output logic                            q_pop,
  sss_report_if.source                    report
);
  import sss_pkg::*;

  localparam int NumLive = (NUM_DIGITS < MaxDigits) ? NUM_DIGITS : MaxDigits;

  logic [SegW-1:0]      cand_seg  [NumLive];
  logic                 cand_pt   [NumLive];
  logic [CountW-1:0]    cnt       [NumLive];
  logic [SegW-1:0]      conf_seg  [NumLive];
  logic                 conf_pt   [NumLive];
  logic [MaxDigits-1:0] fresh;

  logic [CountW-1:0]    cnt_next  [NumLive];
  logic [NumLive-1:0]   hit;
  logic [NumLive-1:0]   confirm;
  logic [MaxDigits-1:0] set_mask;
  logic [MaxDigits-1:0] fresh_next;

  logic [SegW-1:0]      rpt_seg   [MaxDigits];
  logic                 rpt_pt    [MaxDigits];

  logic take_sample;
  logic take_report;
  logic out_free;

  assign out_free    = !report.valid || report.ready;
  assign take_sample = q_valid && (q_data.opcode == OpSample);
  assign take_report = q_valid && (q_data.opcode == OpReport) && out_free;
  assign q_pop       = take_sample || take_report;

  always_comb begin
    set_mask = '0;
    for (int i = 0; i < NumLive; i++) begin
      hit[i] = take_sample && (q_data.digit == DigitW'(i));
      if (cand_seg[i] == q_data.segments && cand_pt[i] == q_data.point) begin
        cnt_next[i] = (cnt[i] < threshold) ? cnt[i] + CountW'(1) : cnt[i];
      end else begin
        cnt_next[i] = CountW'(1);
      end
      confirm[i]  = hit[i] && (cnt_next[i] >= threshold);
      set_mask[i] = confirm[i];
    end
    fresh_next = take_report ? '0 : (fresh | set_mask);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumLive; i++) begin
        cand_seg[i] <= '0;
        cand_pt[i]  <= 1'b0;
        cnt[i]      <= '0;
        conf_seg[i] <= '0;
        conf_pt[i]  <= 1'b0;
      end
      fresh <= '0;
    end else begin
      for (int i = 0; i < NumLive; i++) begin
        if (hit[i]) begin
          cand_seg[i] <= q_data.segments;
          cand_pt[i]  <= q_data.point;
          cnt[i]      <= cnt_next[i];
        end
        if (confirm[i]) begin
          conf_seg[i] <= q_data.segments;
          conf_pt[i]  <= q_data.point;
        end
      end
      fresh <= fresh_next;
    end
  end

  // Report view: absent digits read zero.
  for (genvar g = 0; g < MaxDigits; g++) begin : g_rpt
    if (g < NumLive) begin : g_live
      assign rpt_seg[g] = conf_seg[g];
      assign rpt_pt[g]  = conf_pt[g];
    end else begin : g_absent
      assign rpt_seg[g] = '0;
      assign rpt_pt[g]  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      report.valid <= 1'b0;
    end else if (take_report) begin
      report.valid <= 1'b1;
    end else if (report.ready) begin
      report.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_report) begin
      report.digit0_segments <= rpt_seg[0];
      report.digit1_segments <= rpt_seg[1];
      report.digit2_segments <= rpt_seg[2];
      report.digit0_point    <= rpt_pt[0];
      report.digit1_point    <= rpt_pt[1];
      report.digit2_point    <= rpt_pt[2];
      report.fresh_flags     <= fresh;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/seven_segment_scan_sniffer_core.sv =====
// Seven-segment scan sniffer top level.
// Channels:
//   cmd    - sample bursts (opcode sample) and report requests (opcode report).
//   report - one transaction per report request: confirmed masks, points and
//            fresh flags of digits 0..2; digits that do not exist read zero.
//   cfg    - write of confirm_threshold; always ready, take it while idle.
// Throughput: one cmd transaction per cycle, sustained, as long as report
// is taken; the front checks a sample in the cycle it arrives.
// A transaction is written to the queue when it is accepted and is handled
// by the back end once it reaches the queue head; a report result is
// registered in the report output when its entry is popped.
// Stall: while report is held off, samples keep flowing through the back
// end until a second report reaches the queue head; one more entry fits
// behind it, and once the queue is full cmd.ready drops.
// Reset (rst, synchronous): clears all debounce state, confirmed values,
// fresh flags, the queue and the report valid flag; threshold returns to 3.
// Depends on sss_pkg, sss_ifs, sss_front, sss_queue, sss_back and the
// assertion macro header.
`default_nettype none

`include "seven_segment_scan_sniffer_core_assert.svh"

module seven_segment_scan_sniffer_core #(
  parameter int NUM_DIGITS = 3
) (
  input wire logic      clk,
  input wire logic      rst,
  sss_cmd_if.sink       cmd,
  sss_report_if.source  report,
  sss_cfg_if.sink       cfg
);
  import sss_pkg::*;

  logic [CountW-1:0] threshold;

  sss_op_t push_data;
  sss_op_t head;
  logic    push;
  logic    pop;
  logic    not_full;
  logic    not_empty;

  // Report request taken on cmd, and report entry leaving the queue.
  logic    report_acc;
  logic    report_pop;

  // Threshold register; user must write only while idle, not enforced here.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= ThrReset;
    end else if (cfg.valid) begin
      threshold <= cfg.confirm_threshold;
    end
  end

  // Front: classify, drop inconsistent samples.
  sss_front #(.NUM_DIGITS(NUM_DIGITS)) u_front (
    .cmd     (cmd),
    .q_ready (not_full),
    .q_data  (push_data),
    .q_push  (push)
  );

  // Decoupling queue between front and back.
  sss_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .not_full  (not_full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  // Back: debounce state update and report register.
  sss_back #(.NUM_DIGITS(NUM_DIGITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .threshold (threshold),
    .q_valid   (not_empty),
    .q_data    (head),
    .q_pop     (pop),
    .report    (report)
  );

  assign report_acc = cmd.valid && cmd.ready && (cmd.opcode == OpReport);
  assign report_pop = pop && (head.opcode == OpReport);

  // A report request that is accepted shows up in the queue next cycle.
  `SSS_ASSERT_NEXT(a_report_queued, clk, rst, report_acc, not_empty, "report not queued")
  // Popping a report loads the output register.
  `SSS_ASSERT_NEXT(a_report_loaded, clk, rst, report_pop, report.valid, "report not shown")
  // The output only turns valid because a report was popped.
  `SSS_ASSERT_NOW(a_report_source, clk, rst, $rose(report.valid), $past(report_pop), "stray report")
  // The queue never pops when empty.
  `SSS_ASSERT_NOW(a_no_underflow, clk, rst, pop, not_empty, "queue popped while empty")

endmodule

`default_nettype wire
